// File: rtl/core/pils_pkg.sv
// ----------------------------------------------------------------------------
// Process image layout and split: shared package
// Sizes, result codes, controller states and the command and status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package pils_pkg;

   localparam int MAX_ENTRIES          = 32;
   localparam int OFFSET_BITS          = 16;
   localparam int DEFAULT_MAX_DATAGRAM = 1486;

   localparam int SLAVE_W   = 16;
   localparam int SIZE_W    = 12;
   localparam int ADDR_W    = 32;
   localparam int USERS_W   = 6;
   localparam int STATUS_W  = 3;
   localparam int AOFF_W    = 16;
   localparam int CSR_IDX_W = 2;

   localparam int OFS_W   = OFFSET_BITS;
   localparam int OFS_X_W = OFFSET_BITS + 1;
   localparam int IDX_W   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
   localparam int KEY_W   = SLAVE_W + 1;
   localparam int ENTRY_W = SLAVE_W + 1 + OFS_W + SIZE_W;

   localparam logic OP_ADD    = 1'b0;
   localparam logic OP_FINISH = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_BASE_ADDRESS = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DATAGRAM = CSR_IDX_W'(1);

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK       = 3'd0,
      STAT_FULL     = 3'd1,
      STAT_OVERSIZE = 3'd2,
      STAT_EMPTY    = 3'd3,
      STAT_OVERFLOW = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      EM_NONE,
      EM_ADD,
      EM_OVERSIZE,
      EM_EMPTY,
      EM_SPLIT,
      EM_FINAL
   } emit_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ADD,
      ST_CHK_RD,
      ST_CHK_EV,
      ST_OVERSIZE,
      ST_CHK_END,
      ST_WK_RD,
      ST_WK_EV,
      ST_WK_FIN
   } state_type;

   typedef struct packed {
      logic     load;
      logic     idx_clr;
      logic     idx_inc;
      logic     rd;
      logic     walk_init;
      logic     walk_step;
      emit_type emit;
   } cmd_type;

   typedef struct packed {
      logic is_add;
      logic out_free;
      logic n_zero;
      logic img_zero;
      logic idx_last;
      logic oversize;
      logic split;
   } stat_type;

endpackage

// File: rtl/core/pils_ifs.sv
// ----------------------------------------------------------------------------
// Process image layout and split: channel interfaces
// Request, response and register write channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface pils_req_if;
   logic        valid;
   logic        ready;
   logic        opcode;
   logic [15:0] slave_id;
   logic        direction;
   logic [11:0] entry_bytes;
   logic        overlap_allowed;
   modport source (output valid, opcode, slave_id, direction, entry_bytes,
                   overlap_allowed, input ready);
   modport sink   (input valid, opcode, slave_id, direction, entry_bytes,
                   overlap_allowed, output ready);
endinterface

interface pils_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [15:0] assigned_offset;
   logic [31:0] logical_address;
   logic [11:0] datagram_bytes;
   logic [5:0]  input_users;
   logic [5:0]  output_users;
   logic        last;
   modport source (output valid, status, assigned_offset, logical_address,
                   datagram_bytes, input_users, output_users, last, input ready);
   modport sink   (input valid, status, assigned_offset, logical_address,
                   datagram_bytes, input_users, output_users, last, output ready);
endinterface

interface pils_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [31:0] wdata;
   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

// File: rtl/core/pils_ctrl.sv
// ----------------------------------------------------------------------------
// Process image layout and split: controller
// Sequences add items, the size check pass and the split walk over the table.
// ----------------------------------------------------------------------------
module pils_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  pils_pkg::stat_type stat,
   output pils_pkg::cmd_type  cmd
);
   import pils_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.emit  = EM_NONE;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.load    = 1'b1;
               cmd.idx_clr = 1'b1;
               state_in    = ST_ADD;
            end
         end
         ST_ADD: begin
            if (!stat.is_add) begin
               state_in = stat.n_zero ? ST_CHK_END : ST_CHK_RD;
            end else if (stat.out_free) begin
               cmd.emit = EM_ADD;
               state_in = ST_IDLE;
            end
         end
         ST_CHK_RD: begin
            cmd.rd   = 1'b1;
            state_in = ST_CHK_EV;
         end
         ST_CHK_EV: begin
            if (stat.oversize) begin
               state_in = ST_OVERSIZE;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = stat.idx_last ? ST_CHK_END : ST_CHK_RD;
            end
         end
         ST_OVERSIZE: begin
            if (stat.out_free) begin
               cmd.emit = EM_OVERSIZE;
               state_in = ST_IDLE;
            end
         end
         ST_CHK_END: begin
            if (stat.n_zero || stat.img_zero) begin
               if (stat.out_free) begin
                  cmd.emit = EM_EMPTY;
                  state_in = ST_IDLE;
               end
            end else begin
               cmd.walk_init = 1'b1;
               cmd.idx_clr   = 1'b1;
               state_in      = ST_WK_RD;
            end
         end
         ST_WK_RD: begin
            cmd.rd   = 1'b1;
            state_in = ST_WK_EV;
         end
         ST_WK_EV: begin
            // A split sends out the finished datagram, so it waits for room.
            if (!stat.split || stat.out_free) begin
               cmd.walk_step = 1'b1;
               cmd.idx_inc   = 1'b1;
               cmd.emit      = stat.split ? EM_SPLIT : EM_NONE;
               state_in      = stat.idx_last ? ST_WK_FIN : ST_WK_RD;
            end
         end
         ST_WK_FIN: begin
            if (stat.out_free) begin
               cmd.emit = EM_FINAL;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/core/pils_dpath.sv
// ----------------------------------------------------------------------------
// Process image layout and split: datapath
// Fill pointers, entry table memory, split walk registers and result register.
// ----------------------------------------------------------------------------
module pils_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  pils_pkg::cmd_type                   cmd,
   output pils_pkg::stat_type                  stat,
   input  logic                                req_opcode,
   input  logic [pils_pkg::SLAVE_W-1:0]        req_slave_id,
   input  logic                                req_direction,
   input  logic [pils_pkg::SIZE_W-1:0]         req_entry_bytes,
   input  logic                                req_overlap_allowed,
   input  logic                                csr_valid,
   input  logic [pils_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pils_pkg::ADDR_W-1:0]         csr_wdata,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [pils_pkg::STATUS_W-1:0]       rsp_status,
   output logic [pils_pkg::AOFF_W-1:0]         rsp_assigned_offset,
   output logic [pils_pkg::ADDR_W-1:0]         rsp_logical_address,
   output logic [pils_pkg::SIZE_W-1:0]         rsp_datagram_bytes,
   output logic [pils_pkg::USERS_W-1:0]        rsp_input_users,
   output logic [pils_pkg::USERS_W-1:0]        rsp_output_users,
   output logic                                rsp_last
);
   import pils_pkg::*;

   logic [ADDR_W-1:0]  base_ff;
   logic [SIZE_W-1:0]  max_ff;
   logic               op_ff;
   logic [SLAVE_W-1:0] slave_ff;
   logic               dir_ff;
   logic [SIZE_W-1:0]  size_ff;
   logic               overlap_ff;
   logic [OFS_W-1:0]   fill_in_ff, fill_out_ff, image_ff;
   logic [SLAVE_W-1:0] prev_slave_ff;
   logic               prev_valid_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [ENTRY_W-1:0] mem [MAX_ENTRIES];
   logic [ENTRY_W-1:0] rd_data_ff;
   logic [CNT_W-1:0]   idx_ff;
   logic [OFS_W-1:0]   dg_off_ff, cand_ff;
   logic [KEY_W-1:0]   seen_ff [MAX_ENTRIES];
   logic [CNT_W-1:0]   seen_cnt_ff;
   logic [CNT_W-1:0]   used_in_ff, used_out_ff;

   logic                  out_valid_ff;
   logic [STATUS_W-1:0]   out_status_ff;
   logic [AOFF_W-1:0]     out_off_ff;
   logic [ADDR_W-1:0]     out_addr_ff;
   logic [SIZE_W-1:0]     out_len_ff;
   logic [USERS_W-1:0]    out_in_u_ff, out_out_u_ff;
   logic                  out_last_ff;

   // Add path.
   logic               add_same, add_full, add_ovf, add_ok;
   logic [OFS_W-1:0]   add_base, add_off, add_fin, add_fout;
   logic [OFS_X_W-1:0] add_end;

   always_comb begin
      add_base = (fill_in_ff > fill_out_ff) ? fill_in_ff : fill_out_ff;
      add_same = overlap_ff && prev_valid_ff && (slave_ff == prev_slave_ff);
      if (add_same) begin
         add_off = dir_ff ? fill_in_ff : fill_out_ff;
      end else begin
         add_off = add_base;
      end
      add_end  = {1'b0, add_off} + OFS_X_W'(size_ff);
      add_full = (count_ff >= CNT_W'(MAX_ENTRIES));
      add_ovf  = add_end[OFS_W];
      add_ok   = (cmd.emit == EM_ADD) && !add_full && !add_ovf;
      add_fin  = add_same ? fill_in_ff : add_base;
      add_fout = add_same ? fill_out_ff : add_base;
      if (dir_ff) begin
         add_fin = add_end[OFS_W-1:0];
      end else begin
         add_fout = add_end[OFS_W-1:0];
      end
   end

   // Walk path on the entry just read.
   logic [SIZE_W-1:0]  rd_size;
   logic [OFS_W-1:0]   rd_off, wk_end;
   logic               rd_dir, wk_match, split;
   logic [SLAVE_W-1:0] rd_slave;
   logic [KEY_W-1:0]   rd_key;
   logic [OFS_X_W-1:0] wk_end_x;

   always_comb begin
      rd_size  = rd_data_ff[SIZE_W-1:0];
      rd_off   = rd_data_ff[SIZE_W +: OFS_W];
      rd_dir   = rd_data_ff[SIZE_W + OFS_W];
      rd_slave = rd_data_ff[SIZE_W + OFS_W + 1 +: SLAVE_W];
      rd_key   = {rd_slave, rd_dir};
      wk_end_x = {1'b0, rd_off} + OFS_X_W'(rd_size);
      wk_end   = wk_end_x[OFS_W-1:0];
      split    = (rd_off >= cand_ff) &&
                 ((wk_end_x - {1'b0, dg_off_ff}) > OFS_X_W'(max_ff));
      wk_match = 1'b0;
      for (int k = 0; k < MAX_ENTRIES; k++) begin
         if ((CNT_W'(k) < seen_cnt_ff) && (seen_ff[k] == rd_key)) begin
            wk_match = 1'b1;
         end
      end
   end

   logic out_free;
   assign out_free = !out_valid_ff || rsp_ready;

   always_comb begin
      stat.is_add   = (op_ff == OP_ADD);
      stat.out_free = out_free;
      stat.n_zero   = (count_ff == '0);
      stat.img_zero = (image_ff == '0);
      stat.idx_last = ((idx_ff + CNT_W'(1)) == count_ff);
      stat.oversize = (rd_size > max_ff);
      stat.split    = split;
   end

   // Registers and item latch.
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff       <= '0;
         max_ff        <= SIZE_W'(DEFAULT_MAX_DATAGRAM);
         fill_in_ff    <= '0;
         fill_out_ff   <= '0;
         image_ff      <= '0;
         prev_slave_ff <= '0;
         prev_valid_ff <= 1'b0;
         count_ff      <= '0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_BASE_ADDRESS: base_ff <= csr_wdata;
               CSR_MAX_DATAGRAM: max_ff  <= csr_wdata[SIZE_W-1:0];
               default: ;
            endcase
         end
         if (add_ok) begin
            fill_in_ff    <= add_fin;
            fill_out_ff   <= add_fout;
            image_ff      <= (add_fin > add_fout) ? add_fin : add_fout;
            prev_slave_ff <= slave_ff;
            prev_valid_ff <= 1'b1;
            count_ff      <= count_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff      <= req_opcode;
         slave_ff   <= req_slave_id;
         dir_ff     <= req_direction;
         size_ff    <= req_entry_bytes;
         overlap_ff <= req_overlap_allowed;
      end
   end

   // Entry table: one write port for adds, one registered read port for the size check and the walk.
   always_ff @(posedge clock) begin
      if (add_ok) begin
         mem[count_ff[IDX_W-1:0]] <= {slave_ff, dir_ff, add_off, size_ff};
      end
      if (cmd.rd) begin
         rd_data_ff <= mem[idx_ff[IDX_W-1:0]];
      end
   end

   // Walk state. The seen list holds the slave and direction pairs of the
   // datagram being built, so each pair is counted once per datagram.
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff      <= '0;
         seen_cnt_ff <= '0;
      end else begin
         if (cmd.idx_clr) begin
            idx_ff <= '0;
         end else if (cmd.idx_inc) begin
            idx_ff <= idx_ff + CNT_W'(1);
         end
         if (cmd.walk_init) begin
            seen_cnt_ff <= '0;
         end else if (cmd.walk_step) begin
            if (split) begin
               seen_cnt_ff <= CNT_W'(1);
            end else if (!wk_match) begin
               seen_cnt_ff <= seen_cnt_ff + CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.walk_init) begin
         dg_off_ff   <= '0;
         cand_ff     <= '0;
         used_in_ff  <= '0;
         used_out_ff <= '0;
      end else if (cmd.walk_step) begin
         if (wk_end > cand_ff) begin
            cand_ff <= wk_end;
         end
         if (split) begin
            dg_off_ff   <= cand_ff;
            seen_ff[0]  <= rd_key;
            used_in_ff  <= rd_dir ? CNT_W'(1) : '0;
            used_out_ff <= rd_dir ? '0 : CNT_W'(1);
         end else if (!wk_match) begin
            seen_ff[seen_cnt_ff[IDX_W-1:0]] <= rd_key;
            if (rd_dir) begin
               used_in_ff <= used_in_ff + CNT_W'(1);
            end else begin
               used_out_ff <= used_out_ff + CNT_W'(1);
            end
         end
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit != EM_NONE) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit != EM_NONE) begin
         out_status_ff <= STAT_OK;
         out_off_ff    <= '0;
         out_addr_ff   <= '0;
         out_len_ff    <= '0;
         out_in_u_ff   <= '0;
         out_out_u_ff  <= '0;
         out_last_ff   <= 1'b1;
         case (cmd.emit)
            EM_ADD: begin
               if (add_full) begin
                  out_status_ff <= STAT_FULL;
               end else if (add_ovf) begin
                  out_status_ff <= STAT_OVERFLOW;
               end else begin
                  out_off_ff <= AOFF_W'(add_off);
               end
            end
            EM_OVERSIZE: out_status_ff <= STAT_OVERSIZE;
            EM_EMPTY:    out_status_ff <= STAT_EMPTY;
            EM_SPLIT: begin
               out_addr_ff  <= base_ff + ADDR_W'(dg_off_ff);
               out_len_ff   <= SIZE_W'(cand_ff - dg_off_ff);
               out_in_u_ff  <= USERS_W'(used_in_ff);
               out_out_u_ff <= USERS_W'(used_out_ff);
               out_last_ff  <= 1'b0;
            end
            EM_FINAL: begin
               if (image_ff > dg_off_ff) begin
                  out_addr_ff  <= base_ff + ADDR_W'(dg_off_ff);
                  out_len_ff   <= SIZE_W'(image_ff - dg_off_ff);
                  out_in_u_ff  <= USERS_W'(used_in_ff);
                  out_out_u_ff <= USERS_W'(used_out_ff);
               end else begin
                  out_status_ff <= STAT_EMPTY;
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_status          = out_status_ff;
   assign rsp_assigned_offset = out_off_ff;
   assign rsp_logical_address = out_addr_ff;
   assign rsp_datagram_bytes  = out_len_ff;
   assign rsp_input_users     = out_in_u_ff;
   assign rsp_output_users    = out_out_u_ff;
   assign rsp_last            = out_last_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit != EM_NONE) |-> out_free)
      else $error("result register overwritten while still held");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ENTRIES))
      else $error("entry count beyond table depth");

   a_seen_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.walk_step |-> (seen_cnt_ff <= idx_ff))
      else $error("seen list larger than walked entries");

   a_image_covers: assert property (@(posedge clock) disable iff (reset)
      (image_ff >= fill_in_ff) && (image_ff >= fill_out_ff))
      else $error("image size below a fill pointer");

endmodule

// File: rtl/core/process_image_layout_and_split_unit.sv
// ----------------------------------------------------------------------------
// Process image layout and split unit
// Places mapping entries in a process image and splits it into datagrams.
// ----------------------------------------------------------------------------
// One item at a time. An add item is latched when it is accepted and places
// its result in the output register once that register is free. A finish
// item first reads every table entry to check its size, stopping with an
// oversize result at the first entry larger than the maximum datagram, and
// then reads every entry again for the split walk, all on the single
// registered read port of the entry table. A finish on an empty table or
// image returns an empty result without the walk. Every result waits until
// the output register is free, so the response side can stall the walk at a
// split. The block takes a new item once the previous one has placed its
// final result in the output register. Register writes are taken in every
// cycle outside reset.
module process_image_layout_and_split_unit (
   input logic        clock,
   input logic        reset,
   pils_req_if.sink   req_bus,
   pils_rsp_if.source rsp_bus,
   pils_csr_if.sink   csr_bus
);
   import pils_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   assign csr_bus.ready = !reset;

   pils_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   pils_dpath u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_opcode          (req_bus.opcode),
      .req_slave_id        (req_bus.slave_id),
      .req_direction       (req_bus.direction),
      .req_entry_bytes     (req_bus.entry_bytes),
      .req_overlap_allowed (req_bus.overlap_allowed),
      .csr_valid           (csr_bus.valid),
      .csr_index           (csr_bus.index),
      .csr_wdata           (csr_bus.wdata),
      .rsp_valid           (rsp_bus.valid),
      .rsp_ready           (rsp_bus.ready),
      .rsp_status          (rsp_bus.status),
      .rsp_assigned_offset (rsp_bus.assigned_offset),
      .rsp_logical_address (rsp_bus.logical_address),
      .rsp_datagram_bytes  (rsp_bus.datagram_bytes),
      .rsp_input_users     (rsp_bus.input_users),
      .rsp_output_users    (rsp_bus.output_users),
      .rsp_last            (rsp_bus.last)
   );

endmodule
